// ----- rtl/first_fit_implicit_list_allocator_assert.svh -----
// Assertion macros for the allocator.
`ifndef FIRST_FIT_IMPLICIT_LIST_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_IMPLICIT_LIST_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FFA_ASSERT_IMPL(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FFA_ASSERT_NORST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFA_ASSERT_IMPL(lbl, clk, rst, prop, msg)
`define FFA_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/ffa_pkg.sv -----
package ffa_pkg;
   localparam int ArenaBytes = 65536;
   localparam int AddrW = 17;
   localparam int SlotW = 14;            // 4-byte slots
   localparam int StoreDepth = ArenaBytes / 4;
   localparam int HdrW = 18;             // used mark + 17-bit size

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0, CMD_FREE = 2'd1, CMD_DEFRAG = 2'd2, CMD_INFO = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_NO_SPACE = 2'd1, ST_ZERO_REQ = 2'd2, ST_NOT_STARTED = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LATCH, OP_CUR_RESET, OP_READ_CUR, OP_READ_NXT, OP_READ_FREE,
      OP_ALLOC_SPLIT_TAIL, OP_ALLOC_HEAD, OP_ALLOC_EXTEND, OP_FREE_WRITE,
      OP_INFO_ACC, OP_STEP_CUR, OP_NXT_START, OP_NXT_STEP, OP_MERGE_WRITE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic       zero_req;
      logic       started;
      logic       cur_in_heap;
      logic       nxt_in_heap;
      logic       hdr_short;
      logic       hdr_used;
      logic       fits;
      logic       split;
      logic       extend_ok;
      logic       free_valid;
      cmd_type    cmd;
   } dp_status_type;
endpackage

// ----- rtl/ffa_ram.sv -----
module ffa_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/ffa_datapath.sv -----
module ffa_datapath import ffa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_status_type     sts,
   input  logic [1:0]        req_command,
   input  logic [16:0]       req_request_size,
   input  logic [15:0]       req_block_offset,
   input  logic              csr_write,
   input  logic [16:0]       csr_wdata,
   output logic [15:0]       payload_offset,
   output logic [16:0]       free_bytes,
   output logic [16:0]       largest_free,
   output logic [12:0]       live_count
);
   logic [1:0]   command_ff;
   logic [16:0]  req_size_ff;
   logic [15:0]  blk_off_ff;
   logic [16:0]  limit_ff;
   logic [AddrW-1:0] heap_end_ff, heap_end_in;
   logic         started_ff, started_in;
   logic [AddrW-1:0] cur_ff, cur_in, nxt_ff, nxt_in;
   logic [17:0]  need_ff;
   logic [16:0]  freeb_ff, freeb_in, big_ff, big_in;
   logic [12:0]  live_ff, live_in;
   logic [15:0]  pay_ff, pay_in;

   logic             wr_en;
   logic [SlotW-1:0] wr_addr, rd_addr;
   logic [HdrW-1:0]  wr_data, rd_data;

   ffa_ram #(.Width(HdrW), .Depth(StoreDepth)) u_store (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   logic [16:0] hsize;
   logic        hused;
   logic [17:0] rest;
   logic [18:0] ext_sum;
   logic [16:0] limit_eff;
   logic [17:0] rounded;
   logic [16:0] hoff;
   logic [16:0] tail_off;
   logic [17:0] fsum;

   assign hsize = rd_data[16:0];
   assign hused = rd_data[17];
   assign rest  = {1'b0, hsize} - need_ff;
   assign limit_eff = (limit_ff > 17'(ArenaBytes)) ? 17'(ArenaBytes) : limit_ff;
   assign ext_sum = {2'b0, heap_end_ff} + {1'b0, need_ff};
   assign rounded = ({1'b0, req_size_ff} + 18'd7) & ~18'd7;
   assign hoff = {1'b0, blk_off_ff} - 17'd8;
   assign tail_off = cur_ff + need_ff[16:0];
   assign fsum = {1'b0, freeb_ff} + {1'b0, hsize};

   always_comb begin
      sts.zero_req    = (req_size_ff == 17'd0);
      sts.started     = started_ff;
      sts.cur_in_heap = cur_ff < heap_end_ff;
      sts.nxt_in_heap = nxt_ff < heap_end_ff;
      sts.hdr_short   = hsize < 17'd8;
      sts.hdr_used    = hused;
      sts.fits        = {1'b0, hsize} >= need_ff;
      sts.split       = rest >= 18'd16;
      sts.extend_ok   = ext_sum <= {2'b0, limit_eff};
      sts.free_valid  = blk_off_ff >= 16'd8;
      sts.cmd         = cmd_type'(command_ff);
   end

   always_comb begin
      heap_end_in = heap_end_ff;
      started_in  = started_ff;
      cur_in  = cur_ff;
      nxt_in  = nxt_ff;
      freeb_in = freeb_ff;
      big_in  = big_ff;
      live_in = live_ff;
      pay_in  = pay_ff;
      wr_en   = 1'b0;
      wr_addr = cur_ff[SlotW+1:2];
      wr_data = {1'b1, need_ff[16:0]};
      rd_addr = cur_ff[SlotW+1:2];
      case (cmd.op)
         OP_CUR_RESET: begin
            cur_in = '0; freeb_in = '0; big_in = '0; live_in = '0; pay_in = '0;
            if (command_ff == CMD_ALLOC && !started_ff) begin
               started_in = 1'b1; heap_end_in = '0;
            end
         end
         OP_READ_CUR: rd_addr = cur_ff[SlotW+1:2];
         OP_READ_NXT: rd_addr = nxt_ff[SlotW+1:2];
         OP_READ_FREE: rd_addr = hoff[SlotW+1:2];
         OP_ALLOC_SPLIT_TAIL: begin
            wr_en = tail_off < 17'(ArenaBytes);
            wr_addr = tail_off[SlotW+1:2];
            wr_data = {1'b0, rest[16:0]};
         end
         OP_ALLOC_HEAD: begin
            wr_en = 1'b1;
            wr_data = sts.split ? {1'b1, need_ff[16:0]} : {1'b1, hsize};
            pay_in = cur_ff[15:0] + 16'd8;
         end
         OP_ALLOC_EXTEND: begin
            wr_en = heap_end_ff < 17'(ArenaBytes);
            wr_addr = heap_end_ff[SlotW+1:2];
            pay_in = heap_end_ff[15:0] + 16'd8;
            heap_end_in = ext_sum[16:0];
         end
         OP_FREE_WRITE: begin
            wr_en = 1'b1;
            wr_addr = hoff[SlotW+1:2];
            wr_data = {1'b0, hsize};
         end
         OP_INFO_ACC: begin
            if (hused) begin
               if (live_ff != 13'h1FFF) live_in = live_ff + 13'd1;
            end else begin
               freeb_in = fsum[17] ? 17'h1FFFF : fsum[16:0];
               if (hsize > big_ff) big_in = hsize;
            end
            cur_in = cur_ff + hsize;
         end
         OP_STEP_CUR: cur_in = cur_ff + hsize;
         OP_NXT_START: nxt_in = cur_ff + hsize;
         OP_NXT_STEP: nxt_in = nxt_ff + hsize;
         OP_MERGE_WRITE: begin
            wr_en = 1'b1;
            wr_data = {1'b0, nxt_ff - cur_ff};
            cur_in = nxt_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_end_ff <= '0;
         started_ff  <= 1'b0;
         limit_ff    <= 17'd65536;
      end else begin
         heap_end_ff <= heap_end_in;
         started_ff  <= started_in;
         if (csr_write) limit_ff <= csr_wdata;
      end
      if (cmd.op == OP_LATCH) begin
         command_ff  <= req_command;
         req_size_ff <= req_request_size;
         blk_off_ff  <= req_block_offset;
      end
      need_ff  <= rounded + 18'd8;
      cur_ff   <= cur_in;
      nxt_ff   <= nxt_in;
      freeb_ff <= freeb_in;
      big_ff   <= big_in;
      live_ff  <= live_in;
      pay_ff   <= pay_in;
   end

   assign payload_offset = pay_ff;
   assign free_bytes     = freeb_ff;
   assign largest_free   = big_ff;
   assign live_count     = live_ff;
endmodule

// ----- rtl/ffa_ctrl.sv -----
module ffa_ctrl import ffa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dp_status_type sts,
   output dp_cmd_type    cmd,
   output logic          done,
   output logic [1:0]    status
);
   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_DISPATCH, S_A_RD, S_A_CHK, S_A_TAIL, S_EXT,
      S_F_RD, S_F_WR, S_I_RD, S_I_CHK, S_D_RD, S_D_CHK, S_N_RD, S_N_CHK, S_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic       busy_ff, done_ff, done_in;
   logic [1:0] status_ff, status_in;

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      done_in   = 1'b0;
      status_in = status_ff;
      case (state_ff)
         S_IDLE: if (start) begin cmd.op = OP_LATCH; state_in = S_PREP; end
         S_PREP: state_in = S_DISPATCH; // need settles
         S_DISPATCH: begin
            status_in = ST_OK;
            case (sts.cmd)
               // zero request leaves the heap unstarted
               CMD_ALLOC: if (sts.zero_req) begin
                  status_in = ST_ZERO_REQ; state_in = S_DONE;
               end else begin cmd.op = OP_CUR_RESET; state_in = S_A_RD; end
               CMD_FREE: begin
                  cmd.op = OP_CUR_RESET;
                  state_in = sts.free_valid ? S_F_RD : S_DONE;
               end
               CMD_DEFRAG: begin cmd.op = OP_CUR_RESET; state_in = S_D_RD; end
               default: begin
                  cmd.op = OP_CUR_RESET;
                  if (!sts.started) begin
                     status_in = ST_NOT_STARTED; state_in = S_DONE;
                  end else state_in = S_I_RD;
               end
            endcase
         end
         S_A_RD: if (sts.cur_in_heap) begin
            cmd.op = OP_READ_CUR; state_in = S_A_CHK;
         end else state_in = S_EXT;
         S_A_CHK: begin
            cmd.op = OP_READ_CUR;
            if (sts.hdr_short) state_in = S_EXT;
            else if (!sts.hdr_used && sts.fits) begin
               if (sts.split) begin cmd.op = OP_ALLOC_SPLIT_TAIL; state_in = S_A_TAIL; end
               else begin cmd.op = OP_ALLOC_HEAD; state_in = S_DONE; end
            end else begin cmd.op = OP_STEP_CUR; state_in = S_A_RD; end
         end
         S_A_TAIL: begin cmd.op = OP_ALLOC_HEAD; state_in = S_DONE; end
         S_EXT: begin
            if (sts.extend_ok) cmd.op = OP_ALLOC_EXTEND;
            else status_in = ST_NO_SPACE;
            state_in = S_DONE;
         end
         S_F_RD: begin cmd.op = OP_READ_FREE; state_in = S_F_WR; end
         S_F_WR: begin cmd.op = OP_FREE_WRITE; state_in = S_DONE; end
         S_I_RD: if (sts.cur_in_heap) begin
            cmd.op = OP_READ_CUR; state_in = S_I_CHK;
         end else state_in = S_DONE;
         S_I_CHK: if (sts.hdr_short) state_in = S_DONE;
            else begin cmd.op = OP_INFO_ACC; state_in = S_I_RD; end
         S_D_RD: if (sts.cur_in_heap) begin
            cmd.op = OP_READ_CUR; state_in = S_D_CHK;
         end else state_in = S_DONE;
         S_D_CHK: begin
            cmd.op = OP_READ_CUR;
            if (sts.hdr_short) state_in = S_DONE;
            else if (sts.hdr_used) begin cmd.op = OP_STEP_CUR; state_in = S_D_RD; end
            else begin cmd.op = OP_NXT_START; state_in = S_N_RD; end
         end
         S_N_RD: if (sts.nxt_in_heap) begin
            cmd.op = OP_READ_NXT; state_in = S_N_CHK;
         end else begin cmd.op = OP_MERGE_WRITE; state_in = S_D_RD; end
         S_N_CHK: begin
            cmd.op = OP_READ_NXT;
            if (sts.hdr_used || sts.hdr_short) begin
               cmd.op = OP_MERGE_WRITE; state_in = S_D_RD;
            end else begin cmd.op = OP_NXT_STEP; state_in = S_N_RD; end
         end
         S_DONE: begin done_in = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         busy_ff   <= 1'b0;
         done_ff   <= 1'b0;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= (state_in != S_IDLE);
         done_ff   <= done_in;
         status_ff <= status_in;
      end
   end

   assign busy   = busy_ff;
   assign done   = done_ff;
   assign status = status_ff;
endmodule

// ----- rtl/first_fit_implicit_list_allocator.sv -----
// First-fit allocator over a 64 KiB arena kept as an implicit block chain.
// Input: pulse start with req_command/req_request_size/req_block_offset
// while busy is low; the transfer happens at that edge and busy rises.
// Commands: alloc, free, defrag, info. Every command gives one result:
// rsp_valid is high for exactly one cycle with rsp_status and the fields
// (payload offset for alloc, free bytes/largest/live count for info).
// The receiver cannot stall; results must be taken when shown.
// Zero requests, frees below offset 8 and info before start finish
// without a walk. Alloc, info and defrag read one header at a time; alloc
// stops at the first free block that fits (splitting it or not) or else
// extends the heap, and defrag also reads the neighbors after a free
// block. One command in flight at a time; the next one may transfer in
// the cycle its predecessor's result shows.
// csr_write/csr_wdata set arena_limit at any idle time; limit in effect is
// min(arena_limit, 65536).
// Reset (synchronous, active high) clears heap_end, the started flag and
// the controller; the header store is not cleared, and a free reads
// whatever header lies at its offset.
`include "first_fit_implicit_list_allocator_assert.svh"
module first_fit_implicit_list_allocator import ffa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [16:0] req_request_size,
   input  logic [15:0] req_block_offset,
   input  logic        csr_write,
   input  logic [16:0] csr_wdata,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_payload_offset,
   output logic [16:0] rsp_free_bytes,
   output logic [16:0] rsp_largest_free,
   output logic [12:0] rsp_live_count
);
   dp_cmd_type    dp_cmd;
   dp_status_type dp_sts;
   logic [15:0]   pay;
   logic [16:0]   freeb, big;
   logic [12:0]   live;

   ffa_ctrl u_ctrl (
      .clock, .reset, .start, .busy, .sts(dp_sts), .cmd(dp_cmd),
      .done(rsp_valid), .status(rsp_status)
   );

   ffa_datapath u_dp (
      .clock, .reset, .cmd(dp_cmd), .sts(dp_sts),
      .req_command, .req_request_size, .req_block_offset,
      .csr_write, .csr_wdata,
      .payload_offset(pay), .free_bytes(freeb), .largest_free(big),
      .live_count(live)
   );

   // Non-alloc results report zero offset; only info reports sums.
   assign rsp_payload_offset = (rsp_status == ST_OK && dp_sts.cmd == CMD_ALLOC) ? pay : '0;
   assign rsp_free_bytes   = (rsp_status == ST_OK && dp_sts.cmd == CMD_INFO) ? freeb : '0;
   assign rsp_largest_free = (rsp_status == ST_OK && dp_sts.cmd == CMD_INFO) ? big : '0;
   assign rsp_live_count   = (rsp_status == ST_OK && dp_sts.cmd == CMD_INFO) ? live : '0;

   `FFA_ASSERT_IMPL(a_no_result_idle, clock, reset,
      rsp_valid |-> !busy, "result shown while still busy")
   `FFA_ASSERT_IMPL(a_busy_after_start, clock, reset,
      (start && !busy) |=> busy, "start transfer did not raise busy")
   `FFA_ASSERT_IMPL(a_single_pulse, clock, reset,
      rsp_valid |=> !rsp_valid, "result strobe longer than one cycle")
endmodule

// ----- bench/tb_first_fit_implicit_list_allocator.sv -----
`timescale 1ns / 1ps
module tb_first_fit_implicit_list_allocator;
   import ffa_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;
   localparam int SLOTS = ArenaBytes / 4;

   // one result as the block shows it
   typedef struct {
      status_type  status;
      logic [15:0] payload_offset;
      logic [16:0] free_bytes;
      logic [16:0] largest_free;
      logic [12:0] live_count;
   } alloc_result_type;

   // Scoreboard: shadow heap plus queue of pending results.
   class alloc_scoreboard;
      bit           hdr_used [SLOTS];
      int unsigned  hdr_size [SLOTS];
      bit           hdr_written [SLOTS];
      int unsigned  written_slots [$];   // slots ever written, for stale frees
      int unsigned  live_offsets [$];    // granted payload offsets not yet freed
      int unsigned  heap_end;
      bit           heap_started;
      int unsigned  arena_limit;
      alloc_result_type pending_results [$];
      int           errors;

      function new();
         heap_end = 0;
         heap_started = 0;
         arena_limit = 65536;
         errors = 0;
      endfunction

      function void hdr_put(int unsigned off, bit used, int unsigned size);
         int unsigned s;
         s = off / 4;
         if (off >= ArenaBytes) return;
         if (!hdr_written[s]) written_slots.push_back(s);
         hdr_written[s] = 1;
         hdr_used[s] = used;
         hdr_size[s] = size;
      endfunction

      function void drop_live(int unsigned off);
         foreach (live_offsets[i])
            if (live_offsets[i] == off) begin
               live_offsets.delete(i);
               return;
            end
      endfunction

      function void run_alloc(int unsigned req, ref alloc_result_type r);
         int unsigned need, cur, sz, lim;
         if (req == 0) begin
            r.status = ST_ZERO_REQ;
            return;
         end
         heap_started = 1;
         need = (req + 7) / 8 * 8 + 8;
         cur = 0;
         while (cur < heap_end) begin
            sz = hdr_size[cur/4];
            if (sz < 8) break;
            if (!hdr_used[cur/4] && sz >= need) begin
               // split only when the tail can hold a header plus a granule
               if (sz - need >= 16) begin
                  hdr_put(cur + need, 0, sz - need);
                  hdr_put(cur, 1, need);
               end else begin
                  hdr_put(cur, 1, sz);
               end
               r.payload_offset = 16'(cur + 8);
               live_offsets.push_back(cur + 8);
               return;
            end
            cur += sz;
         end
         lim = (arena_limit < ArenaBytes) ? arena_limit : ArenaBytes;
         if (heap_end + need > lim) begin
            r.status = ST_NO_SPACE;
            return;
         end
         hdr_put(heap_end, 1, need);
         r.payload_offset = 16'(heap_end + 8);
         live_offsets.push_back(heap_end + 8);
         heap_end += need;
      endfunction

      function void run_free(int unsigned off);
         int unsigned h;
         if (off < 8) return;
         h = off - 8;
         hdr_put(h, 0, hdr_size[h/4]);
         drop_live((h / 4) * 4 + 8);
      endfunction

      function void run_defrag();
         int unsigned cur, nxt, sz, ns;
         cur = 0;
         while (cur < heap_end) begin
            sz = hdr_size[cur/4];
            if (sz < 8) break;
            if (!hdr_used[cur/4]) begin
               nxt = cur + sz;
               while (nxt < heap_end) begin
                  ns = hdr_size[nxt/4];
                  if (hdr_used[nxt/4] || ns < 8) break;
                  nxt += ns;
               end
               sz = nxt - cur;
               hdr_put(cur, 0, sz);
            end
            cur += sz;
         end
      endfunction

      function void run_info(ref alloc_result_type r);
         int unsigned cur, sz, fb, big, live;
         if (!heap_started) begin
            r.status = ST_NOT_STARTED;
            return;
         end
         cur = 0; fb = 0; big = 0; live = 0;
         while (cur < heap_end) begin
            sz = hdr_size[cur/4];
            if (sz < 8) break;
            if (hdr_used[cur/4]) live++;
            else begin
               fb += sz;
               if (sz > big) big = sz;
            end
            cur += sz;
         end
         r.free_bytes   = (fb > 17'h1FFFF) ? 17'h1FFFF : 17'(fb);
         r.largest_free = (big > 17'h1FFFF) ? 17'h1FFFF : 17'(big);
         r.live_count   = (live > 13'h1FFF) ? 13'h1FFF : 13'(live);
      endfunction

      // called at the edge where a command transfer happens
      function void note_command(cmd_type cmd, int unsigned req, int unsigned off);
         alloc_result_type r;
         r.status = ST_OK;
         r.payload_offset = '0;
         r.free_bytes = '0;
         r.largest_free = '0;
         r.live_count = '0;
         case (cmd)
            CMD_ALLOC:  run_alloc(req, r);
            CMD_FREE:   run_free(off);
            CMD_DEFRAG: run_defrag();
            default:    run_info(r);
         endcase
         pending_results.push_back(r);
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %0h want %0h", what, got, want);
         errors++;
      endtask

      task check_result(alloc_result_type got);
         alloc_result_type w;
         if (pending_results.size() == 0) begin
            report("unexpected result", got.status, 0);
            return;
         end
         w = pending_results.pop_front();
         if (got.status !== w.status) report("status", got.status, w.status);
         if (got.payload_offset !== w.payload_offset)
            report("payload_offset", got.payload_offset, w.payload_offset);
         if (got.free_bytes !== w.free_bytes)
            report("free_bytes", got.free_bytes, w.free_bytes);
         if (got.largest_free !== w.largest_free)
            report("largest_free", got.largest_free, w.largest_free);
         if (got.live_count !== w.live_count)
            report("live_count", got.live_count, w.live_count);
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_command;
   logic [16:0] req_request_size;
   logic [15:0] req_block_offset;
   logic        csr_write;
   logic [16:0] csr_wdata;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_payload_offset;
   logic [16:0] rsp_free_bytes;
   logic [16:0] rsp_largest_free;
   logic [12:0] rsp_live_count;

   alloc_scoreboard sb;
   int          idle_pct;      // sender gap odds for the current phase
   int          watchdog;

   first_fit_implicit_list_allocator uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_request_size(req_request_size),
      .req_block_offset(req_block_offset),
      .csr_write(csr_write), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_payload_offset(rsp_payload_offset), .rsp_free_bytes(rsp_free_bytes),
      .rsp_largest_free(rsp_largest_free), .rsp_live_count(rsp_live_count)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Result monitor: a result is only ever up for one cycle, so take it
   // at the edge that closes that cycle.
   always @(posedge clock) begin
      alloc_result_type got;
      if (!reset && rsp_valid && sb != null) begin
         got.status = status_type'(rsp_status);
         got.payload_offset = rsp_payload_offset;
         got.free_bytes = rsp_free_bytes;
         got.largest_free = rsp_largest_free;
         got.live_count = rsp_live_count;
         sb.check_result(got);
      end
   end

   // Watchdog: counts cycles with no transfer on either side.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Drive one command and hold it until the transfer. start is left high
   // afterwards; the next call or an idle gap decides what happens next.
   task send_command(cmd_type cmd, int unsigned req, int unsigned off);
      start <= 1'b1;
      req_command <= cmd;
      req_request_size <= 17'(req);
      req_block_offset <= 16'(off);
      do @(posedge clock); while (busy);
      sb.note_command(cmd, req, off);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   endtask

   // Let everything in flight drain so the block is idle.
   task drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_results.size() != 0 || busy) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task write_limit(int unsigned v);
      drain();
      csr_write <= 1'b1;
      csr_wdata <= 17'(v);
      @(posedge clock);
      csr_write <= 1'b0;
      sb.arena_limit = v;
      @(posedge clock);
   endtask

   // Pick a free target: mostly a live block, sometimes a stale header
   // (any slot ever written), sometimes an offset too low to count.
   function int unsigned pick_free_offset();
      int unsigned p, v;
      p = $urandom_range(99);
      if (p < 70 && sb.live_offsets.size() != 0)
         return sb.live_offsets[$urandom_range(sb.live_offsets.size() - 1)];
      if (p < 92 && sb.written_slots.size() != 0) begin
         v = sb.written_slots[$urandom_range(sb.written_slots.size() - 1)] * 4 + 8;
         v += $urandom_range(3);   // low bits get floored away
         if (v <= 65535) return v;
      end
      return $urandom_range(7);
   endfunction

   function int unsigned pick_size();
      int unsigned p;
      p = $urandom_range(99);
      if (p < 3) return 0;
      if (p < 8) return $urandom_range(1, 65536);
      if (p < 30) return $urandom_range(1, 64);
      return $urandom_range(65, 3000);
   endfunction

   task random_phase(int n);
      int unsigned p;
      for (int i = 0; i < n; i++) begin
         p = $urandom_range(99);
         if (p < 50) send_command(CMD_ALLOC, pick_size(), $urandom);
         else if (p < 80) send_command(CMD_FREE, $urandom, pick_free_offset());
         else if (p < 88) send_command(CMD_DEFRAG, $urandom, $urandom);
         else send_command(CMD_INFO, $urandom, $urandom);
      end
   endtask

   initial begin
      int unsigned a, b, c;
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_INFO;
      req_request_size = '0;
      req_block_offset = '0;
      csr_write = 1'b0;
      csr_wdata = '0;
      idle_pct = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: commands before the heap is started
      send_command(CMD_INFO, 0, 0);
      send_command(CMD_FREE, 0, 0);
      send_command(CMD_FREE, 0, 5);
      send_command(CMD_DEFRAG, 0, 0);
      send_command(CMD_ALLOC, 0, 0);            // zero request, heap stays idle
      send_command(CMD_INFO, 0, 0);
      // first allocs, rounding edges, a too-large request
      send_command(CMD_ALLOC, 1, 0);
      send_command(CMD_ALLOC, 8, 0);
      send_command(CMD_ALLOC, 9, 0);
      send_command(CMD_ALLOC, 200, 0);
      send_command(CMD_ALLOC, 65536, 0);
      send_command(CMD_ALLOC, 17'h1FFFF & 65535, 0);
      a = sb.live_offsets[3];
      b = sb.live_offsets[1];
      c = sb.live_offsets[2];
      send_command(CMD_FREE, 0, a + 2);         // unaligned offset floors to slot
      send_command(CMD_ALLOC, 16, 0);           // fits and splits the tail
      send_command(CMD_ALLOC, 150, 0);          // fits the freed tail and splits it again
      send_command(CMD_FREE, 0, b);
      send_command(CMD_FREE, 0, c);
      send_command(CMD_FREE, 0, c);             // double free, no check
      send_command(CMD_INFO, 0, 0);
      send_command(CMD_DEFRAG, 0, 0);           // merge the adjacent pair
      send_command(CMD_INFO, 0, 0);
      send_command(CMD_ALLOC, 24, 0);

      // phases: limit setting and sender idle odds change between them
      write_limit(131071);                      // above the arena, clipped
      random_phase(250);
      write_limit(4096);
      idle_pct = 47;
      random_phase(200);
      write_limit(0);                           // every extension fails
      idle_pct = 0;
      random_phase(60);
      write_limit($urandom_range(1, 65536));
      idle_pct = 35;
      random_phase(240);
      write_limit(65536);
      idle_pct = 0;
      random_phase(250);

      drain();
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
